@@ sv/bsa_pkg.sv @@
// Shared definitions for the bitmap slot allocator: field widths, beat layouts,
// operation and status codes, and the command/status bundles between controller
// and datapath. No dependencies.
package bsa_pkg;

  localparam int unsigned MAX_SLOTS_DEFAULT = 4096;
  localparam int unsigned WORD_BITS_DEFAULT = 32;
  localparam int unsigned SLOT_COUNT_RESET  = 4096;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned SLOT_W   = 12;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 13;

  // Input beat: opcode [1:0], slot [13:2], run_length [26:14].
  localparam int unsigned S_TDATA_W   = 32;
  localparam int unsigned IN_SLOT_LSB = 2;
  localparam int unsigned IN_LEN_LSB  = 14;

  // Result beat: first_slot [11:0], granted_length [24:12], status [26:25].
  localparam int unsigned M_TDATA_W      = 32;
  localparam int unsigned OUT_LEN_LSB    = 12;
  localparam int unsigned OUT_STATUS_LSB = 25;

  localparam logic [OPCODE_W-1:0] OP_ALLOC_NEAR = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ALLOC_RUN  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FREE       = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_UNUSED     = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PARTIAL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_UNUSED  = 2'd3;

  typedef struct packed {
    logic load;       // latch a new request
    logic rd;         // read the bitmap word at the current address
    logic near_hit;   // claim the lowest free bit of the word just read
    logic near_next;  // advance the near scan by one word
    logic no_free;    // report that no slot is free
    logic run_load;   // load the word just read into the bit shifter
    logic run_bit;    // examine one slot of the run scan
    logic mark_init;  // fix the grant and point at its first word
    logic mark_wr;    // set the granted bits in the word just read
    logic free_wr;    // clear the freed bit in the word just read
    logic emit;       // move the result into the output register
  } bsa_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                no_slots;
    logic                free_skip;
    logic                near_found;
    logic                near_last;
    logic                run_hit;
    logic                run_last;
    logic                word_end;
    logic                best_zero;
    logic                mark_last;
    logic                out_free;
  } bsa_stat_t;

endpackage

@@ sv/bsa_ctrl.sv @@
// Controller state machine of the bitmap slot allocator.
// Depends on bsa_pkg; drives bsa_datapath through bsa_cmd_t and reads bsa_stat_t.
module bsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  bsa_pkg::bsa_stat_t stat,
  output bsa_pkg::bsa_cmd_t  cmd
);

  typedef enum logic [3:0] {
    IDLE, DISPATCH, NEAR_RD, NEAR_CHK, RUN_RD, RUN_LOAD, RUN_BIT, RUN_END,
    MARK_RD, MARK_WR, FREE_WR, DONE
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A configuration beat wins over a request beat in the same cycle.
  assign cfg_ready = (state == IDLE);
  assign s_tready  = (state == IDLE) && !cfg_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (s_tvalid && !cfg_valid) begin
          cmd.load   = 1'b1;
          state_next = DISPATCH;
        end
      end
      DISPATCH: begin
        case (stat.opcode)
          bsa_pkg::OP_ALLOC_NEAR: begin
            if (stat.no_slots) begin
              cmd.no_free = 1'b1;
              state_next  = DONE;
            end else begin
              cmd.rd     = 1'b1;
              state_next = NEAR_CHK;
            end
          end
          bsa_pkg::OP_ALLOC_RUN: begin
            if (stat.no_slots) begin
              cmd.no_free = 1'b1;
              state_next  = DONE;
            end else begin
              cmd.rd     = 1'b1;
              state_next = RUN_LOAD;
            end
          end
          bsa_pkg::OP_FREE: begin
            if (stat.free_skip) begin
              state_next = DONE;
            end else begin
              cmd.rd     = 1'b1;
              state_next = FREE_WR;
            end
          end
          default: state_next = DONE;
        endcase
      end
      NEAR_RD: begin
        cmd.rd     = 1'b1;
        state_next = NEAR_CHK;
      end
      NEAR_CHK: begin
        if (stat.near_found) begin
          cmd.near_hit = 1'b1;
          state_next   = DONE;
        end else if (stat.near_last) begin
          cmd.no_free = 1'b1;
          state_next  = DONE;
        end else begin
          cmd.near_next = 1'b1;
          state_next    = NEAR_RD;
        end
      end
      RUN_RD: begin
        cmd.rd     = 1'b1;
        state_next = RUN_LOAD;
      end
      RUN_LOAD: begin
        cmd.run_load = 1'b1;
        state_next   = RUN_BIT;
      end
      RUN_BIT: begin
        cmd.run_bit = 1'b1;
        if (stat.run_hit || stat.run_last) begin
          state_next = RUN_END;
        end else if (stat.word_end) begin
          state_next = RUN_RD;
        end
      end
      RUN_END: begin
        if (stat.best_zero) begin
          cmd.no_free = 1'b1;
          state_next  = DONE;
        end else begin
          cmd.mark_init = 1'b1;
          state_next    = MARK_RD;
        end
      end
      MARK_RD: begin
        cmd.rd     = 1'b1;
        state_next = MARK_WR;
      end
      MARK_WR: begin
        cmd.mark_wr = 1'b1;
        state_next  = stat.mark_last ? DONE : MARK_RD;
      end
      FREE_WR: begin
        cmd.free_wr = 1'b1;
        state_next  = DONE;
      end
      DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

endmodule

@@ sv/bsa_datapath.sv @@
// Datapath of the bitmap slot allocator: bitmap memory with per-word valid bits,
// scan counters, run tracking, result and output registers. Depends on bsa_pkg.
module bsa_datapath #(
  parameter int unsigned MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEFAULT,
  parameter int unsigned WORD_BITS = bsa_pkg::WORD_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bsa_pkg::bsa_cmd_t              cmd,
  output bsa_pkg::bsa_stat_t             stat,
  input  logic [bsa_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                           cfg_we,
  input  logic [bsa_pkg::COUNT_W-1:0]    cfg_data,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bsa_pkg::M_TDATA_W-1:0]  m_tdata
);

  localparam int unsigned NUM_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned BW = $clog2(WORD_BITS);
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned NW = CW + 1;
  localparam int unsigned RESET_COUNT =
    (bsa_pkg::SLOT_COUNT_RESET > MAX_SLOTS) ? MAX_SLOTS : bsa_pkg::SLOT_COUNT_RESET;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic                 vld [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic                 rvld;

  logic [CW-1:0]                 slot_count;
  logic [bsa_pkg::OPCODE_W-1:0]  opcode;
  logic [bsa_pkg::SLOT_W-1:0]    op_slot;
  logic [bsa_pkg::LEN_W-1:0]     need;
  logic [AW-1:0]                 addr;
  logic [NW-1:0]                 wcount;
  logic [CW-1:0]                 s;
  logic [WORD_BITS-1:0]          bits;
  logic [BW-1:0]                 bidx;
  logic [CW-1:0]                 cur_start, cur_len, best_start, best_len;
  logic                          full;
  logic [bsa_pkg::SLOT_W-1:0]    res_first;
  logic [bsa_pkg::LEN_W-1:0]     res_len;
  logic [bsa_pkg::STATUS_W-1:0]  res_status;

  logic [bsa_pkg::OPCODE_W-1:0]  in_op;
  logic [bsa_pkg::SLOT_W-1:0]    in_slot;
  logic [bsa_pkg::LEN_W-1:0]     in_len;
  logic [NW-1:0]                 nw_words, in_word, base, slot_found;
  logic [WORD_BITS-1:0]          word, beyond, masked, mark_mask, wdata;
  logic [BW-1:0]                 zidx, mlo, mhi;
  logic                          free_b, run_hit, run_last;
  logic [CW-1:0]                 new_len, run_start, close_len, close_start, hi_slot;
  logic [AW-1:0]                 lo_w, hi_w, addr_wrap;
  logic                          wr_en;

  assign in_op   = s_tdata[bsa_pkg::OPCODE_W-1:0];
  assign in_slot = s_tdata[bsa_pkg::IN_SLOT_LSB +: bsa_pkg::SLOT_W];
  assign in_len  = s_tdata[bsa_pkg::IN_LEN_LSB +: bsa_pkg::LEN_W];

  assign nw_words = (NW'(slot_count) + NW'(WORD_BITS - 1)) >> BW;
  assign in_word  = NW'(in_slot >> BW);
  assign word     = rvld ? rdata : '0;
  assign base     = NW'(addr) << BW;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      beyond[b] = (base + NW'(b)) >= NW'(slot_count);
    end
  end
  assign masked = word | beyond;

  always_comb begin
    zidx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!masked[b]) zidx = BW'(b);
    end
  end
  assign slot_found = base + NW'(zidx);
  assign addr_wrap  = ((NW'(addr) + NW'(1)) == nw_words) ? '0 : addr + 1'b1;

  // One slot of the run scan.
  assign free_b      = ~bits[0];
  assign new_len     = cur_len + 1'b1;
  assign run_start   = (cur_len == '0) ? s : cur_start;
  assign run_hit     = free_b && (32'(new_len) >= 32'(need));
  assign run_last    = (NW'(s) + NW'(1)) == NW'(slot_count);
  assign close_len   = free_b ? new_len : cur_len;
  assign close_start = free_b ? run_start : cur_start;

  // Bits of the current word that fall inside the granted run.
  assign hi_slot = best_start + best_len - 1'b1;
  assign lo_w    = AW'(best_start >> BW);
  assign hi_w    = AW'(hi_slot >> BW);
  assign mlo     = (addr == lo_w) ? best_start[BW-1:0] : '0;
  assign mhi     = (addr == hi_w) ? hi_slot[BW-1:0] : '1;
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mark_mask[b] = (BW'(b) >= mlo) && (BW'(b) <= mhi);
    end
  end

  assign wr_en = cmd.near_hit || cmd.mark_wr || cmd.free_wr;
  always_comb begin
    if (cmd.near_hit) begin
      wdata = word | (WORD_BITS'(1) << zidx);
    end else if (cmd.mark_wr) begin
      wdata = word | mark_mask;
    end else begin
      wdata = word & ~(WORD_BITS'(1) << op_slot[BW-1:0]);
    end
  end

  always_comb begin
    stat            = '0;
    stat.opcode     = opcode;
    stat.no_slots   = (slot_count == '0);
    stat.free_skip  = 32'(op_slot) >= 32'(slot_count);
    stat.near_found = ~&masked;
    stat.near_last  = (wcount + NW'(1)) == nw_words;
    stat.run_hit    = run_hit;
    stat.run_last   = run_last;
    stat.word_end   = (bidx == BW'(WORD_BITS - 1));
    stat.best_zero  = (best_len == '0);
    stat.mark_last  = (addr == hi_w);
    stat.out_free   = !m_tvalid || m_tready;
  end

  // Bitmap storage; payload only, validity lives in vld.
  always_ff @(posedge clk) begin
    if (wr_en) mem[addr] <= wdata;
    if (cmd.rd) rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) vld[i] <= 1'b0;
      rvld       <= 1'b0;
      slot_count <= CW'(RESET_COUNT);
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        for (int i = 0; i < NUM_WORDS; i++) vld[i] <= 1'b0;
        slot_count <= (32'(cfg_data) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(cfg_data);
      end else if (wr_en) begin
        vld[addr] <= 1'b1;
      end
      if (cmd.rd) rvld <= vld[addr];
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opcode     <= in_op;
      op_slot    <= in_slot;
      need       <= (in_len == '0) ? bsa_pkg::LEN_W'(1) : in_len;
      wcount     <= '0;
      s          <= '0;
      bidx       <= '0;
      cur_len    <= '0;
      cur_start  <= '0;
      best_len   <= '0;
      best_start <= '0;
      full       <= 1'b0;
      res_first  <= '0;
      res_len    <= '0;
      res_status <= bsa_pkg::STATUS_FULL;
      if (in_op == bsa_pkg::OP_FREE) begin
        addr <= AW'(in_slot >> BW);
      end else if (in_op == bsa_pkg::OP_ALLOC_NEAR && in_word < nw_words) begin
        addr <= AW'(in_word);
      end else begin
        addr <= '0;
      end
    end
    if (cmd.near_hit) begin
      res_first <= bsa_pkg::SLOT_W'(slot_found);
      res_len   <= bsa_pkg::LEN_W'(1);
    end
    if (cmd.near_next) begin
      addr   <= addr_wrap;
      wcount <= wcount + 1'b1;
    end
    if (cmd.no_free) res_status <= bsa_pkg::STATUS_NO_FREE;
    if (cmd.run_load) bits <= word;
    if (cmd.run_bit) begin
      s    <= s + 1'b1;
      bits <= bits >> 1;
      bidx <= bidx + 1'b1;
      if (bidx == BW'(WORD_BITS - 1)) addr <= addr + 1'b1;
      if (run_hit) begin
        best_start <= run_start;
        best_len   <= CW'(need);
        full       <= 1'b1;
      end else begin
        if ((!free_b || run_last) && close_len > best_len) begin
          best_start <= close_start;
          best_len   <= close_len;
        end
        cur_len   <= free_b ? new_len : '0;
        cur_start <= run_start;
      end
    end
    if (cmd.mark_init) begin
      addr       <= lo_w;
      res_first  <= bsa_pkg::SLOT_W'(best_start);
      res_len    <= bsa_pkg::LEN_W'(best_len);
      res_status <= full ? bsa_pkg::STATUS_FULL : bsa_pkg::STATUS_PARTIAL;
    end
    if (cmd.mark_wr) addr <= addr + 1'b1;
    if (cmd.emit) begin
      m_tdata <= bsa_pkg::M_TDATA_W'({res_status, res_len, res_first});
    end
  end

endmodule

@@ sv/bitmap_slot_allocator.sv @@
// Top level of the bitmap slot allocator: joins the controller and the datapath.
// Depends on bsa_pkg, bsa_ctrl and bsa_datapath.
//
//   Channel   Direction  Beat contents (low bits first)
//   s_*       in         opcode[1:0], slot[13:2], run_length[26:14]
//   m_*       out        first_slot[11:0], granted_length[24:12], status[26:25]
//   cfg_*     in         slot_count[12:0]; writing it clears the whole map
//
// One request is in work at a time. Allocate-near reads the map one word after
// another until a word has a free slot or every word has been read. Allocate-run
// walks the map one slot per cycle, pausing to read each new word, then reads and
// rewrites each word it marks. A free reads and rewrites one word, and touches no
// word when the slot lies at or above slot_count; the bitmap memory is single-port
// with a registered read. A finished result that finds the output register still
// holding an unread beat waits until that beat leaves. Reset (rst, synchronous) and
// a configuration write clear the map at once through per-word valid bits. A new
// request is taken while a finished result still waits in the output register.
module bitmap_slot_allocator #(
  parameter int unsigned MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEFAULT,
  parameter int unsigned WORD_BITS = bsa_pkg::WORD_BITS_DEFAULT  // power of two
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // opcode [1:0], slot [13:2], run_length [26:14], zero above
  input  logic [bsa_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // first_slot [11:0], granted_length [24:12], status [26:25], zero above
  output logic [bsa_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsa_pkg::COUNT_W-1:0]   cfg_data
);

  bsa_pkg::bsa_cmd_t  cmd;
  bsa_pkg::bsa_stat_t stat;

  // The controller only sequences; every address and count sits in the datapath.
  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ sv/bsa_checker.sv @@
// Port-level checks for the bitmap slot allocator, bound to the top level.
// Depends on bsa_pkg and bitmap_slot_allocator.
module bsa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [bsa_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  logic [bsa_pkg::STATUS_W-1:0] st;
  assign st = m_tdata[bsa_pkg::OUT_STATUS_LSB +: bsa_pkg::STATUS_W];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !cfg_ready)
    else $error("block ready again right after taking a request");

  a_cfg_first: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && cfg_valid))
    else $error("request taken in the same cycle as a configuration write");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> st != bsa_pkg::STATUS_UNUSED)
    else $error("undefined status code");

  a_nofree: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st == bsa_pkg::STATUS_NO_FREE
      |-> m_tdata[bsa_pkg::OUT_STATUS_LSB-1:0] == '0)
    else $error("no-free result carries a grant");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);
